// ===== hw/rtl/csvtok_pkg.sv =====
// Shared types and constants for the CSV record tokenizer.
// Depends on nothing; the top level takes every name from here by scope.
package csvtok_pkg;

  // Byte codes that steer the tokenizer.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Configuration port.
  localparam int CFG_DATA_W = 13;
  localparam logic CFG_ROW_LIMIT   = 1'b0;
  localparam logic CFG_FIELD_LIMIT = 1'b1;
  localparam logic [12:0] ROW_LIMIT_RESET   = 13'd4096;
  localparam logic [6:0]  FIELD_LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_ROW_LONG   = 2'd0,
    ERR_FIELDS     = 2'd1,
    ERR_STRAY_QT   = 2'd2,
    ERR_UNTERM_QT  = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [11:0] byte_offset;
    logic [12:0] field_length;
    logic [5:0]  field_index;
    err_e        error_code;
  } result_t;

endpackage

// ===== hw/rtl/csv_record_tokenizer.sv =====
// CSV record tokenizer: splits a byte stream into fields and records.
// Depends on csvtok_pkg for byte codes, result kinds and the result struct.

// The tokenizer takes one item per clock cycle: a CSV byte or an end-of-input
// marker. Each item is decoded by a single layer of logic against the parse
// state (field start, plain, quoted, after a closing quote) and its result,
// if any, is registered into the output register, or into the skid register
// while the output register holds an untaken result. Items that make no result
// (an opening quote, a closing quote, the LF of a CRLF) are absorbed with no
// output. The output side has a result register backed by one skid register,
// so a stalled consumer does not stop input until both are full; with the
// consumer always ready the sustained rate is one item per cycle. Quoted
// fields may hold commas, CR and LF, and a doubled quote stands for one
// quote. A record ends at CR, LF or CRLF. Errors (row too long, too many
// fields, stray quote, unterminated quote at end) come out as results of kind
// error. The row and field limits in use are the smaller of the configuration
// register and the ROW_BYTES or MAX_FIELDS parameter. There is no memory and
// no start-up sweep; the block is ready right after reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module csv_record_tokenizer #(
  parameter int ROW_BYTES  = 4096,
  parameter int MAX_FIELDS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [csvtok_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [7:0]                        data_byte_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        kind_o,
  output logic [7:0]                        out_byte_o,
  output logic [11:0]                       byte_offset_o,
  output logic [12:0]                       field_length_o,
  output logic [5:0]                        field_index_o,
  output logic [1:0]                        error_code_o
);

  // Row counters are sized from ROW_BYTES, field counters from MAX_FIELDS.
  // The compare widths also cover the configuration registers.
  localparam int RowW  = $clog2(ROW_BYTES + 1);
  localparam int FldW  = $clog2(MAX_FIELDS + 1);
  localparam int RowCW = (RowW > 13) ? RowW : 13;
  localparam int FldCW = (FldW > 7) ? FldW : 7;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_PLAIN  = 2'd1,
    PH_QUOTED = 2'd2,
    PH_AFTERQ = 2'd3
  } phase_e;

  // Configuration registers.
  logic [12:0] row_limit_q;
  logic [6:0]  field_limit_q;

  // Parse state.
  phase_e          phase_q, phase_d;
  logic            pending_cr_q, pending_cr_d;
  logic            bytes_seen_q, bytes_seen_d;
  logic [RowW-1:0] row_len_q, row_len_d;
  logic [RowW-1:0] open_start_q, open_start_d;
  logic [FldW-1:0] fields_q, fields_d;

  // Output register and skid register.
  logic                out_valid_q, skid_valid_q;
  csvtok_pkg::result_t out_q, skid_q;

  // Decode of the current item.
  logic                res_valid;
  csvtok_pkg::result_t res;
  logic                close_req, close_row, push_req;
  logic                in_fire, out_fire;

  logic [RowCW-1:0] row_lim, row_len_x, open_x, len_x;
  logic [FldCW-1:0] fld_lim, fields_x;
  logic             row_full, fields_full;
  logic             is_quote, is_comma, is_lf, is_cr;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~skid_valid_q;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_q & out_ready_i;

  assign is_quote = (data_byte_i == csvtok_pkg::CH_QUOTE);
  assign is_comma = (data_byte_i == csvtok_pkg::CH_COMMA);
  assign is_lf    = (data_byte_i == csvtok_pkg::CH_LF);
  assign is_cr    = (data_byte_i == csvtok_pkg::CH_CR);

  // Limits in use and the two full checks.
  assign row_len_x = RowCW'(row_len_q);
  assign open_x    = RowCW'(open_start_q);
  assign len_x     = row_len_x - open_x;
  assign fields_x  = FldCW'(fields_q);
  assign row_lim   = (RowCW'(row_limit_q) < RowCW'(ROW_BYTES)) ?
                     RowCW'(row_limit_q) : RowCW'(ROW_BYTES);
  assign fld_lim   = (FldCW'(field_limit_q) < FldCW'(MAX_FIELDS)) ?
                     FldCW'(field_limit_q) : FldCW'(MAX_FIELDS);
  assign row_full    = (row_len_x >= row_lim);
  assign fields_full = (fields_x >= fld_lim);

  always_comb begin
    phase_d      = phase_q;
    pending_cr_d = pending_cr_q;
    bytes_seen_d = bytes_seen_q;
    row_len_d    = row_len_q;
    open_start_d = open_start_q;
    fields_d     = fields_q;
    res_valid    = 1'b0;
    res          = '0;
    close_req    = 1'b0;
    close_row    = 1'b0;
    push_req     = 1'b0;

    // First pick what the item asks for.
    if (action_i) begin
      if (phase_q == PH_QUOTED) begin
        res_valid      = 1'b1;
        res.kind       = csvtok_pkg::KIND_ERROR;
        res.error_code = csvtok_pkg::ERR_UNTERM_QT;
      end else begin
        pending_cr_d = 1'b0;
        // A final record is closed only if it holds anything.
        if (bytes_seen_q || (fields_q != '0)) begin
          close_req = 1'b1;
          close_row = 1'b1;
        end
      end
    end else if (!(pending_cr_q && is_lf)) begin
      pending_cr_d = 1'b0;
      unique case (phase_q)
        PH_START, PH_PLAIN: begin
          bytes_seen_d = 1'b1;
          if (is_comma) begin
            close_req = 1'b1;
          end else if (is_lf || is_cr) begin
            close_req    = 1'b1;
            close_row    = 1'b1;
            pending_cr_d = is_cr;
          end else if (is_quote) begin
            if (phase_q == PH_PLAIN) begin
              res_valid      = 1'b1;
              res.kind       = csvtok_pkg::KIND_ERROR;
              res.error_code = csvtok_pkg::ERR_STRAY_QT;
            end else begin
              phase_d = PH_QUOTED;
            end
          end else begin
            push_req = 1'b1;
            phase_d  = PH_PLAIN;
          end
        end
        PH_QUOTED: begin
          bytes_seen_d = 1'b1;
          if (is_quote) begin
            phase_d = PH_AFTERQ;
          end else begin
            push_req = 1'b1;
          end
        end
        PH_AFTERQ: begin
          if (is_quote) begin
            // Doubled quote: one literal quote, back inside the field.
            push_req = 1'b1;
            phase_d  = PH_QUOTED;
          end else if (is_comma) begin
            close_req = 1'b1;
          end else if (is_lf || is_cr) begin
            close_req    = 1'b1;
            close_row    = 1'b1;
            pending_cr_d = is_cr;
          end else begin
            res_valid      = 1'b1;
            res.kind       = csvtok_pkg::KIND_ERROR;
            res.error_code = csvtok_pkg::ERR_STRAY_QT;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else begin
      // The LF of a CRLF is swallowed.
      pending_cr_d = 1'b0;
    end

    // Then carry out a data byte or a field close.
    if (push_req) begin
      res_valid = 1'b1;
      if (row_full) begin
        res.kind       = csvtok_pkg::KIND_ERROR;
        res.error_code = csvtok_pkg::ERR_ROW_LONG;
      end else begin
        res.kind        = csvtok_pkg::KIND_DATA;
        res.out_byte    = data_byte_i;
        res.byte_offset = row_len_x[11:0];
        row_len_d       = row_len_q + RowW'(1);
      end
    end

    if (close_req) begin
      res_valid = 1'b1;
      if (fields_full) begin
        res.kind       = csvtok_pkg::KIND_ERROR;
        res.error_code = csvtok_pkg::ERR_FIELDS;
      end else begin
        res.kind         = close_row ? csvtok_pkg::KIND_RECORD : csvtok_pkg::KIND_FIELD;
        res.byte_offset  = open_x[11:0];
        res.field_length = len_x[12:0];
        res.field_index  = fields_x[5:0];
        phase_d          = PH_START;
        if (close_row) begin
          row_len_d    = '0;
          open_start_d = '0;
          fields_d     = '0;
          bytes_seen_d = 1'b0;
        end else begin
          open_start_d = row_len_q;
          fields_d     = fields_q + FldW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_limit_q   <= csvtok_pkg::ROW_LIMIT_RESET;
      field_limit_q <= csvtok_pkg::FIELD_LIMIT_RESET;
      phase_q       <= PH_START;
      pending_cr_q  <= 1'b0;
      bytes_seen_q  <= 1'b0;
      row_len_q     <= '0;
      open_start_q  <= '0;
      fields_q      <= '0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
      out_q         <= '0;
      skid_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          csvtok_pkg::CFG_ROW_LIMIT:   row_limit_q   <= cfg_data_i[12:0];
          csvtok_pkg::CFG_FIELD_LIMIT: field_limit_q <= cfg_data_i[6:0];
          default:                     row_limit_q   <= row_limit_q;
        endcase
      end

      if (in_fire) begin
        phase_q      <= phase_d;
        pending_cr_q <= pending_cr_d;
        bytes_seen_q <= bytes_seen_d;
        row_len_q    <= row_len_d;
        open_start_q <= open_start_d;
        fields_q     <= fields_d;
      end

      // A held skid entry moves up first; no item is taken meanwhile.
      if (skid_valid_q) begin
        if (out_fire) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid_q || out_fire) begin
          out_q       <= res;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= res;
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign out_byte_o     = out_q.out_byte;
  assign byte_offset_o  = out_q.byte_offset;
  assign field_length_o = out_q.field_length;
  assign field_index_o  = out_q.field_index;
  assign error_code_o   = out_q.error_code;

  // The skid register is only filled behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  // The open field never starts past the end of the stored row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_x <= row_len_x)
    else $error("open field start beyond row length");

  // Stored bytes and closed fields stay within their limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_len_x <= RowCW'(ROW_BYTES) && fields_x <= FldCW'(MAX_FIELDS))
    else $error("row or field counter exceeds its storage limit");

  // A completed record close leaves the row empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && close_req && close_row && !fields_full) |=>
      (row_len_q == '0 && fields_q == '0 && phase_q == PH_START))
    else $error("record close did not reset the row state");

endmodule
